>>> design/clut_pkg.sv
// Shared types, constants and arithmetic helpers for the colour LUT predictor.
// No dependencies; used by colour_lut_trilinear_predict.
package clut_pkg;

   localparam int LUT_SIDE    = 8;
   localparam int AXIS_W      = 3;
   localparam int IDX_W       = 9;
   localparam int ENTRY_W     = 16;
   localparam int PIX_W       = 8;
   localparam int REFL_W      = 16;
   localparam int PRED_W      = 18;
   localparam int NUM_CH      = 3;
   localparam int NUM_BANKS   = 8;
   localparam int BANK_AW     = 3 * (AXIS_W - 1);
   localparam int BANK_DEPTH  = 1 << BANK_AW;
   localparam int W_FULL      = 255;
   localparam logic [39:0] HALF_CUBE = 40'd8290687;
   localparam logic [PRED_W-1:0] PRED_MAX = '1;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_PREDICT = 1'b1;

   typedef struct packed {
      logic [AXIS_W-1:0] seg;
      logic [7:0]        frac;
   } axis_split_type;

   // cell = 7p / 255, fraction = 7p mod 255; top intensity pinned to last cell
   function automatic axis_split_type split_axis(input logic [PIX_W-1:0] p);
      logic [10:0]       t;
      logic [AXIS_W-1:0] c;
      axis_split_type    s;
      t = 11'(LUT_SIDE - 1) * {3'b000, p};
      c = '0;
      for (int k = 1; k < LUT_SIDE; k++) begin
         if (t >= 11'(k * W_FULL)) c = c + 1'b1;
      end
      if (p == 8'hFF) begin
         s.seg  = AXIS_W'(LUT_SIDE - 2);
         s.frac = 8'hFF;
      end else begin
         s.seg  = c;
         s.frac = 8'(t - {8'b0, c} * 11'd255);
      end
      return s;
   endfunction

   // linear blend of two corners, weights (255-f) and f
   function automatic logic [23:0] lerp16(input logic [15:0] e0, input logic [15:0] e1,
                                          input logic [7:0] f);
      return {8'b0, e0} * {16'b0, 8'hFF - f} + {8'b0, e1} * {16'b0, f};
   endfunction

   function automatic logic [31:0] lerp24(input logic [23:0] e0, input logic [23:0] e1,
                                          input logic [7:0] f);
      return {8'b0, e0} * {24'b0, 8'hFF - f} + {8'b0, e1} * {24'b0, f};
   endfunction

   function automatic logic [39:0] lerp32(input logic [31:0] e0, input logic [31:0] e1,
                                          input logic [7:0] f);
      return {8'b0, e0} * {32'b0, 8'hFF - f} + {8'b0, e1} * {32'b0, f};
   endfunction

   // x/255 estimate from 1/255 = sum of 2^-8k; low by at most 5
   function automatic logic [39:0] div255_est(input logic [39:0] x);
      return (x >> 8) + (x >> 16) + (x >> 24) + (x >> 32);
   endfunction

   // exact quotient: remainder is small, so count whole 255s left over
   function automatic logic [39:0] div255_fix(input logic [39:0] q0, input logic [10:0] xl);
      logic [10:0] m;
      logic [10:0] r;
      logic [2:0]  c;
      m = {q0[2:0], 8'b0} - q0[10:0];
      r = xl - m;
      c = '0;
      for (int k = 1; k < 8; k++) begin
         if (r >= 11'(k * W_FULL)) c = c + 1'b1;
      end
      return q0 + {37'b0, c};
   endfunction

endpackage

>>> design/colour_lut_trilinear_predict.sv
// Top level of the colour LUT predictor: banked table memory and a twelve-stage
// trilinear, divide and reflectance pipeline. Depends on clut_pkg.
//
// A load transfer (mode 0) writes one 8x8x8 table entry; a predict transfer (mode 1)
// yields one result; one item is taken every clock while rsp_ready does not stall it. The table
// sits in eight memories banked by the parity of x, y and z, so the eight corners of
// any cell fall in distinct banks and are fetched together. Each stage has its
// own handshake, so bubbles close up behind a stalled result. There is no clearing pass
// after reset: entries read before they are written return arbitrary data.
module colour_lut_trilinear_predict (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [clut_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [clut_pkg::ENTRY_W-1:0]  req_entry_c0,
   input  logic [clut_pkg::ENTRY_W-1:0]  req_entry_c1,
   input  logic [clut_pkg::ENTRY_W-1:0]  req_entry_c2,
   input  logic [clut_pkg::PIX_W-1:0]    req_pixel_c0,
   input  logic [clut_pkg::PIX_W-1:0]    req_pixel_c1,
   input  logic [clut_pkg::PIX_W-1:0]    req_pixel_c2,
   input  logic [clut_pkg::REFL_W-1:0]   req_refl_c0,
   input  logic [clut_pkg::REFL_W-1:0]   req_refl_c1,
   input  logic [clut_pkg::REFL_W-1:0]   req_refl_c2,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [clut_pkg::PRED_W-1:0]   rsp_pred_c0,
   output logic [clut_pkg::PRED_W-1:0]   rsp_pred_c1,
   output logic [clut_pkg::PRED_W-1:0]   rsp_pred_c2
);
   import clut_pkg::*;

   localparam int NS = 12;
   localparam int RS = 10;

   // stage handshake
   logic [NS:1]   vld_ff;
   logic [NS:1]   vld_in;
   logic [NS+1:1] rdy;
   logic          accept;

   always_comb begin
      rdy[NS+1] = rsp_ready;
      for (int k = NS; k >= 1; k--) rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   assign req_ready = rdy[1];
   assign accept    = req_valid && req_ready;

   always_comb begin
      vld_in[1] = accept && (req_mode == MODE_PREDICT);
      for (int k = 2; k <= NS; k++) vld_in[k] = vld_ff[k-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   // axis split and bank addressing
   axis_split_type          sx, sy, sz;
   logic [AXIS_W-1:0]       wx, wy, wz;
   logic [2:0]              wr_bank;
   logic [BANK_AW-1:0]      wr_addr;
   logic                    wr_en;
   logic [BANK_AW-1:0]      rd_addr [NUM_BANKS];
   logic [3*ENTRY_W-1:0]    wr_data;

   assign sx = split_axis(req_pixel_c0);
   assign sy = split_axis(req_pixel_c1);
   assign sz = split_axis(req_pixel_c2);

   assign wx      = req_entry_index[AXIS_W-1:0];
   assign wy      = req_entry_index[2*AXIS_W-1:AXIS_W];
   assign wz      = req_entry_index[3*AXIS_W-1:2*AXIS_W];
   assign wr_bank = {wz[0], wy[0], wx[0]};
   assign wr_addr = {wz[AXIS_W-1:1], wy[AXIS_W-1:1], wx[AXIS_W-1:1]};
   assign wr_en   = accept && (req_mode == MODE_LOAD);
   assign wr_data = {req_entry_c2, req_entry_c1, req_entry_c0};

   // each bank takes whichever of the two corners along an axis has its parity
   always_comb begin
      logic [AXIS_W-1:0] ax, ay, az;
      for (int b = 0; b < NUM_BANKS; b++) begin
         ax = (sx.seg[0] == b[0]) ? sx.seg : sx.seg + 1'b1;
         ay = (sy.seg[0] == b[1]) ? sy.seg : sy.seg + 1'b1;
         az = (sz.seg[0] == b[2]) ? sz.seg : sz.seg + 1'b1;
         rd_addr[b] = {az[AXIS_W-1:1], ay[AXIS_W-1:1], ax[AXIS_W-1:1]};
      end
   end

   // table memories, one write and one read port each
   logic [3*ENTRY_W-1:0] rd_ff [NUM_BANKS];

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [3*ENTRY_W-1:0] bank_mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == 3'(b))) bank_mem[wr_addr] <= wr_data;
      end

      always_ff @(posedge clock) begin
         if (rdy[1]) rd_ff[b] <= bank_mem[rd_addr[b]];
      end
   end

   // stage 1 side data
   logic [2:0]        par_ff;
   logic [7:0]        fx1_ff, fy1_ff, fz1_ff;
   logic [REFL_W-1:0] refl_ff [1:RS][NUM_CH];

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         par_ff        <= {sz.seg[0], sy.seg[0], sx.seg[0]};
         fx1_ff        <= sx.frac;
         fy1_ff        <= sy.frac;
         fz1_ff        <= sz.frac;
         refl_ff[1][0] <= req_refl_c0;
         refl_ff[1][1] <= req_refl_c1;
         refl_ff[1][2] <= req_refl_c2;
      end
      for (int k = 2; k <= RS; k++) begin
         if (rdy[k]) refl_ff[k] <= refl_ff[k-1];
      end
   end

   // stage 2: blend along x
   logic [23:0] a_in [4][NUM_CH];
   logic [23:0] a_ff [4][NUM_CH];
   logic [7:0]  fy2_ff, fz2_ff;

   always_comb begin
      logic [2:0]  b0, b1;
      logic [47:0] e0, e1;
      for (int g = 0; g < 4; g++) begin
         b0 = {par_ff[2] ^ g[1], par_ff[1] ^ g[0], par_ff[0]};
         b1 = {par_ff[2] ^ g[1], par_ff[1] ^ g[0], ~par_ff[0]};
         e0 = rd_ff[b0];
         e1 = rd_ff[b1];
         for (int c = 0; c < NUM_CH; c++) begin
            a_in[g][c] = lerp16(e0[c*ENTRY_W +: ENTRY_W], e1[c*ENTRY_W +: ENTRY_W], fx1_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         a_ff   <= a_in;
         fy2_ff <= fy1_ff;
         fz2_ff <= fz1_ff;
      end
   end

   // stage 3: blend along y
   logic [31:0] b_ff [2][NUM_CH];
   logic [7:0]  fz3_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         for (int z = 0; z < 2; z++) begin
            for (int c = 0; c < NUM_CH; c++) begin
               b_ff[z][c] <= lerp24(a_ff[2*z][c], a_ff[2*z+1][c], fy2_ff);
            end
         end
         fz3_ff <= fz2_ff;
      end
   end

   // stage 4: blend along z, add half of 255^3 for rounding
   logic [39:0] n_ff [NUM_CH];

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         for (int c = 0; c < NUM_CH; c++) begin
            n_ff[c] <= lerp32(b_ff[0][c], b_ff[1][c], fz3_ff) + HALF_CUBE;
         end
      end
   end

   // stages 5 to 10: three exact divides by 255, estimate then fix each
   logic [31:0] q5_ff  [NUM_CH];
   logic [10:0] l5_ff  [NUM_CH];
   logic [31:0] q6_ff  [NUM_CH];
   logic [23:0] q7_ff  [NUM_CH];
   logic [10:0] l7_ff  [NUM_CH];
   logic [23:0] q8_ff  [NUM_CH];
   logic [15:0] q9_ff  [NUM_CH];
   logic [10:0] l9_ff  [NUM_CH];
   logic [15:0] blend_ff [NUM_CH];
   logic [39:0] est5_in [NUM_CH];
   logic [39:0] fix6_in [NUM_CH];
   logic [39:0] est7_in [NUM_CH];
   logic [39:0] fix8_in [NUM_CH];
   logic [39:0] est9_in [NUM_CH];
   logic [39:0] fix10_in [NUM_CH];

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         est5_in[c]  = div255_est(n_ff[c]);
         fix6_in[c]  = div255_fix({8'b0, q5_ff[c]}, l5_ff[c]);
         est7_in[c]  = div255_est({8'b0, q6_ff[c]});
         fix8_in[c]  = div255_fix({16'b0, q7_ff[c]}, l7_ff[c]);
         est9_in[c]  = div255_est({16'b0, q8_ff[c]});
         fix10_in[c] = div255_fix({24'b0, q9_ff[c]}, l9_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CH; c++) begin
         if (rdy[5]) begin
            q5_ff[c] <= est5_in[c][31:0];
            l5_ff[c] <= n_ff[c][10:0];
         end
         if (rdy[6]) q6_ff[c] <= fix6_in[c][31:0];
         if (rdy[7]) begin
            q7_ff[c] <= est7_in[c][23:0];
            l7_ff[c] <= q6_ff[c][10:0];
         end
         if (rdy[8]) q8_ff[c] <= fix8_in[c][23:0];
         if (rdy[9]) begin
            q9_ff[c] <= est9_in[c][15:0];
            l9_ff[c] <= q8_ff[c][10:0];
         end
         if (rdy[10]) blend_ff[c] <= fix10_in[c][15:0];
      end
   end

   // stage 11: reflectance multiply
   logic [31:0] prod_ff [NUM_CH];

   always_ff @(posedge clock) begin
      if (rdy[11]) begin
         for (int c = 0; c < NUM_CH; c++) prod_ff[c] <= blend_ff[c] * refl_ff[RS][c];
      end
   end

   // stage 12: round to Q10.8 and saturate into the output register
   logic [PRED_W-1:0] pred_in [NUM_CH];
   logic [PRED_W-1:0] pred_ff [NUM_CH];

   always_comb begin
      logic [32:0] rnd;
      for (int c = 0; c < NUM_CH; c++) begin
         rnd = ({1'b0, prod_ff[c]} + 33'd8192) >> 14;
         pred_in[c] = (rnd > {15'b0, PRED_MAX}) ? PRED_MAX : rnd[PRED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[12]) pred_ff <= pred_in;
   end

   assign rsp_valid   = vld_ff[NS];
   assign rsp_pred_c0 = pred_ff[0];
   assign rsp_pred_c1 = pred_ff[1];
   assign rsp_pred_c2 = pred_ff[2];

endmodule
